@@ rtl/tfes_pkg.sv @@
`default_nettype none

package tfes_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned CUR_W    = 33;
  localparam int unsigned BYTES_W  = 17;
  localparam int unsigned NUM_TIERS = 5;

  // operation codes carried by an input beat
  localparam logic OP_START = 1'b0;
  localparam logic OP_ACK   = 1'b1;

  // configuration register indexes
  localparam logic [0:0] REG_REGION_FIRST = 1'b0;
  localparam logic [0:0] REG_REGION_LAST  = 1'b1;

  // erase size codes
  localparam logic [1:0] SIZE_4K  = 2'd0;
  localparam logic [1:0] SIZE_32K = 2'd1;
  localparam logic [1:0] SIZE_64K = 2'd2;

  localparam logic [15:0] TICKS_SHORT = 16'd22223;
  localparam logic [15:0] TICKS_LONG  = 16'd55556;

  // plan tiers, one-hot, plus the finished state
  typedef enum logic [5:0] {
    PH_LEAD_4K   = 6'b000001,
    PH_LEAD_32K  = 6'b000010,
    PH_BULK_64K  = 6'b000100,
    PH_TRAIL_32K = 6'b001000,
    PH_TRAIL_4K  = 6'b010000,
    PH_DONE      = 6'b100000
  } phase_t;

  typedef logic [2:0] tier_t;

  typedef struct packed {
    logic        command_valid;
    logic [31:0] erase_address;
    logic [1:0]  erase_size;
    logic [15:0] timeout_ticks;
    logic        done_res;
    logic        range_error;
  } rsp_t;

  typedef struct packed {
    phase_t next_phase;
    rsp_t   rsp;
  } plan_t;

  // size code of a tier by its position in the plan
  function automatic logic [1:0] tier_size(input tier_t t);
    logic [1:0] code;
    case (t)
      3'd0:    code = SIZE_4K;
      3'd1:    code = SIZE_32K;
      3'd2:    code = SIZE_64K;
      3'd3:    code = SIZE_32K;
      3'd4:    code = SIZE_4K;
      default: code = SIZE_4K;
    endcase
    return code;
  endfunction

  // sector length in bytes of the tier the plan stands in
  function automatic logic [BYTES_W-1:0] phase_bytes(input phase_t p);
    logic [BYTES_W-1:0] b;
    case (p)
      PH_LEAD_4K, PH_TRAIL_4K:   b = 17'h01000;
      PH_LEAD_32K, PH_TRAIL_32K: b = 17'h08000;
      PH_BULK_64K:               b = 17'h10000;
      default:                   b = '0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tfes_planner.sv @@
`default_nettype none

module tfes_planner (
  input  wire logic [tfes_pkg::CUR_W-1:0]  cursor,
  input  wire logic [tfes_pkg::ADDR_W-1:0] tail,
  input  wire tfes_pkg::phase_t            start_phase,
  output tfes_pkg::plan_t                  plan
);

  logic                            below;
  logic [tfes_pkg::CUR_W:0]        last_4k;
  logic [tfes_pkg::CUR_W:0]        last_32k;
  logic [tfes_pkg::CUR_W:0]        last_64k;
  logic [tfes_pkg::CUR_W:0]        tail_wide;
  logic                            fits_4k;
  logic                            fits_32k;
  logic                            fits_64k;
  logic [tfes_pkg::NUM_TIERS-1:0]  ok;
  logic [tfes_pkg::NUM_TIERS-1:0]  reach;
  logic [tfes_pkg::NUM_TIERS-1:0]  hit;
  tfes_pkg::tier_t                 sel;
  logic [1:0]                      size_code;

  // test whether each sector size still fits below the tail
  always_comb begin
    tail_wide = {2'b00, tail};
    below     = cursor < tail_wide[tfes_pkg::CUR_W-1:0];
    last_4k   = {1'b0, cursor} + 34'h0_0000_0FFF;
    last_32k  = {1'b0, cursor} + 34'h0_0000_7FFF;
    last_64k  = {1'b0, cursor} + 34'h0_0000_FFFF;
    fits_4k   = last_4k  <= tail_wide;
    fits_32k  = last_32k <= tail_wide;
    fits_64k  = last_64k <= tail_wide;
  end

  // qualify each tier, then take the first one at or after the start tier
  always_comb begin
    ok[0] = below && (cursor[14:0] != 15'd0) && fits_4k;
    ok[1] = below && (cursor[15:0] != 16'd0) && fits_32k;
    ok[2] = below && fits_64k;
    ok[3] = below && fits_32k;
    ok[4] = below && fits_4k;

    reach[0] = start_phase[0];
    for (int i = 1; i < tfes_pkg::NUM_TIERS; i++) begin
      reach[i] = reach[i-1] | start_phase[i];
    end
    hit = reach & ok;

    sel = '0;
    for (int i = tfes_pkg::NUM_TIERS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        sel = tfes_pkg::tier_t'(i);
      end
    end
    size_code = tfes_pkg::tier_size(sel);
  end

  // build the command, or report the range done
  always_comb begin
    plan = '0;
    if (|hit) begin
      plan.next_phase        = tfes_pkg::phase_t'(6'(6'd1 << sel));
      plan.rsp.command_valid = 1'b1;
      plan.rsp.erase_address = cursor[tfes_pkg::ADDR_W-1:0];
      plan.rsp.erase_size    = size_code;
      plan.rsp.timeout_ticks = (size_code == tfes_pkg::SIZE_4K) ?
                               tfes_pkg::TICKS_SHORT : tfes_pkg::TICKS_LONG;
    end else begin
      plan.next_phase   = tfes_pkg::PH_DONE;
      plan.rsp.done_res = 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tiered_flash_erase_sequencer.sv @@
// Tiered flash erase sequencer.
// Input channel (in_valid / in_stall): a start beat (operation 0) carries the
// head and inclusive tail of a range; an acknowledge beat (operation 1) tells
// the block the last erase finished. Every input beat yields exactly one
// result beat on the output channel (out_valid / out_stall): an erase command
// (address, size code, timeout), done when the range is exhausted, a range
// error for a rejected start, or all zero for an acknowledge while idle.
// The configuration channel (cfg_valid / cfg_ready, always ready) writes
// region_first (index 0) and region_last (index 1); write it only while idle.
// A result is registered in the output register, or in the skid register
// while the receiver stalls. Throughput is one item per cycle while in_stall
// is low, set by the single planning pass between input and output register.
// When the receiver stalls, the held result stays put and one more item is
// taken into a skid register; in_stall rises only while that skid register is
// full, so no result is lost or reordered.
// Reset clears the region to the full address space, leaves the block idle
// and empties the output and skid registers.
`default_nettype none

module tiered_flash_erase_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        operation,
  input  wire logic [31:0] first_address,
  input  wire logic [31:0] last_address,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             command_valid,
  output logic [31:0]      erase_address,
  output logic [1:0]       erase_size,
  output logic [15:0]      timeout_ticks,
  output logic             done_res,
  output logic             range_error,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [tfes_pkg::ADDR_W-1:0] region_first;
  logic [tfes_pkg::ADDR_W-1:0] region_last;
  logic [tfes_pkg::CUR_W-1:0]  cursor_address;
  logic [tfes_pkg::CUR_W-1:0]  cursor_address_next;
  logic [tfes_pkg::ADDR_W-1:0] tail_bound;
  logic [tfes_pkg::ADDR_W-1:0] tail_bound_next;
  tfes_pkg::phase_t            tier_phase;
  tfes_pkg::phase_t            tier_phase_next;

  logic                        in_fire;
  logic                        out_free;
  logic                        busy;
  logic                        range_ok;
  logic [tfes_pkg::CUR_W-1:0]  plan_cursor;
  logic [tfes_pkg::ADDR_W-1:0] plan_tail;
  tfes_pkg::phase_t            plan_phase;
  tfes_pkg::plan_t             plan;
  tfes_pkg::rsp_t              step_rsp;

  tfes_pkg::rsp_t              out_rsp;
  tfes_pkg::rsp_t              skid_rsp;
  logic                        skid_valid;

  assign in_stall  = skid_valid;
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;
  assign busy      = (tier_phase != tfes_pkg::PH_DONE);

  // check the start range against the region
  assign range_ok = (first_address >= region_first) && (first_address <= region_last) &&
                    (last_address >= region_first) && (last_address <= region_last) &&
                    (last_address > first_address);

  // pick the planner inputs: a fresh range, or step past the last sector
  always_comb begin
    if (operation == tfes_pkg::OP_START) begin
      plan_cursor = {1'b0, first_address};
      plan_tail   = last_address;
      plan_phase  = tfes_pkg::PH_LEAD_4K;
    end else begin
      plan_cursor = cursor_address +
                    {{(tfes_pkg::CUR_W - tfes_pkg::BYTES_W){1'b0}},
                     tfes_pkg::phase_bytes(tier_phase)};
      plan_tail   = tail_bound;
      plan_phase  = tier_phase;
    end
  end

  tfes_planner u_planner (
    .cursor      (plan_cursor),
    .tail        (plan_tail),
    .start_phase (plan_phase),
    .plan        (plan)
  );

  // settle the result and the next plan state for this beat
  always_comb begin
    step_rsp            = '0;
    cursor_address_next = cursor_address;
    tail_bound_next     = tail_bound;
    tier_phase_next     = tier_phase;
    if (operation == tfes_pkg::OP_START && !range_ok) begin
      step_rsp.range_error = 1'b1;
      tier_phase_next      = tfes_pkg::PH_DONE;
    end else if (operation == tfes_pkg::OP_START || busy) begin
      step_rsp            = plan.rsp;
      cursor_address_next = plan_cursor;
      tail_bound_next     = plan_tail;
      tier_phase_next     = plan.next_phase;
    end
  end

  // hold the plan state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_address <= '0;
      tail_bound     <= '0;
      tier_phase     <= tfes_pkg::PH_DONE;
    end else if (in_fire) begin
      cursor_address <= cursor_address_next;
      tail_bound     <= tail_bound_next;
      tier_phase     <= tier_phase_next;
    end
  end

  // write the region registers
  always_ff @(posedge clk) begin
    if (rst) begin
      region_first <= '0;
      region_last  <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tfes_pkg::REG_REGION_FIRST: region_first <= cfg_data;
        tfes_pkg::REG_REGION_LAST:  region_last  <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // move the payload along with the valid bits
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_rsp <= skid_rsp;
      end else if (in_fire) begin
        out_rsp <= step_rsp;
      end
    end else if (in_fire) begin
      skid_rsp <= step_rsp;
    end
  end

  assign command_valid = out_rsp.command_valid;
  assign erase_address = out_rsp.erase_address;
  assign erase_size    = out_rsp.erase_size;
  assign timeout_ticks = out_rsp.timeout_ticks;
  assign done_res      = out_rsp.done_res;
  assign range_error   = out_rsp.range_error;

endmodule

`default_nettype wire
